// ===== hw/rtl/sha1_pkg.sv =====
// SHA-1 engine package: shared types, constants and helper functions.
// Used by sha1_window, sha1_round and sha1_hash_engine_core. No dependencies.
`timescale 1ns / 1ps

package sha1_pkg;

    localparam int DIGEST_N = 5;

    localparam logic [6:0]  LAST_ROUND  = 7'd79;
    localparam logic [3:0]  LEN_HI_SLOT = 4'd14;
    localparam logic [3:0]  LAST_SLOT   = 4'd15;
    localparam logic [2:0]  LAST_INDEX  = 3'd4;
    localparam logic [2:0]  FULL_BYTES  = 3'd4;
    localparam logic [31:0] MARKER_WORD = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    // Padding progress of the current message
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MARK,
        PH_ZERO,
        PH_LEN,
        PH_DONE
    } pad_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } work_t;

    // Window control: push loads a message word, step expands one schedule word
    typedef struct packed {
        logic push;
        logic step;
    } win_ctrl_t;

    function automatic logic [31:0] iv_word(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6745_2301;
            3'd1:    v = 32'hEFCD_AB89;
            3'd2:    v = 32'h98BA_DCFE;
            3'd3:    v = 32'h1032_5476;
            default: v = 32'hC3D2_E1F0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

endpackage

// ===== hw/rtl/sha1_hash_engine_core.sv =====
// SHA-1 hash engine top level: stream ports, sequencer, chaining words, padding.
// Depends on sha1_pkg, sha1_window and sha1_round.
// Operation: a message word is taken while idle; every sixteenth word (message or
// padding) starts a compression that holds the block busy for 80 passes of the
// shared round unit, then one chaining add. After the last word, padding pushes
// one word per cycle between compressions, one or two compressions follow,
// then five digest requests leave one per cycle while m_axis_tready is high.
// Reset (rst_n low, asynchronous) loads the initial chaining value and idles.
`timescale 1ns / 1ps

module sha1_hash_engine_core
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Message requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] message_word
    input  logic [2:0]  s_axis_tuser,   // [2:0] bytes_valid
    input  logic        s_axis_tlast,   // is_last
    // Digest requests
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // final_word
);

    state_t      state_reg, state_next;
    pad_t        pad_reg, pad_next;
    logic [3:0]  slot_reg, slot_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] bits_reg, bits_next;
    logic [31:0] chain_reg [DIGEST_N];
    logic [31:0] chain_next [DIGEST_N];
    work_t       work_reg, work_next;

    win_ctrl_t   win_ctrl;
    logic [31:0] push_data;
    logic [31:0] sched_word;
    work_t       round_out;
    logic        in_acc;
    logic        out_acc;
    logic [2:0]  nb_sat;
    logic [31:0] keep_mask;

    sha1_window u_window (
        .clk       (clk),
        .ctrl      (win_ctrl),
        .push_word (push_data),
        .cur_word  (sched_word)
    );

    sha1_round u_round (
        .cur        (work_reg),
        .sched_word (sched_word),
        .round      (round_reg),
        .nxt        (round_out)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = (idx_reg == LAST_INDEX);

    always_comb
    begin
        case (idx_reg)
            3'd0:    m_axis_tdata = chain_reg[0];
            3'd1:    m_axis_tdata = chain_reg[1];
            3'd2:    m_axis_tdata = chain_reg[2];
            3'd3:    m_axis_tdata = chain_reg[3];
            default: m_axis_tdata = chain_reg[4];
        endcase
    end

    // Saturate the byte count and build the mask of valid leading bytes
    always_comb
    begin
        nb_sat = (s_axis_tuser > FULL_BYTES) ? FULL_BYTES : s_axis_tuser;
        case (nb_sat)
            3'd0:    keep_mask = 32'h0000_0000;
            3'd1:    keep_mask = 32'hFF00_0000;
            3'd2:    keep_mask = 32'hFFFF_0000;
            3'd3:    keep_mask = 32'hFFFF_FF00;
            default: keep_mask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pad_next   = pad_reg;
        slot_next  = slot_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        bits_next  = bits_reg;
        work_next  = work_reg;
        for (int i = 0; i < DIGEST_N; i++)
        begin
            chain_next[i] = chain_reg[i];
        end
        win_ctrl  = '0;
        push_data = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    win_ctrl.push = 1'b1;
                    if (!s_axis_tlast)
                    begin
                        // Short words that are not last count as full
                        push_data = s_axis_tdata;
                        bits_next = bits_reg + 64'd32;
                    end
                    else
                    begin
                        bits_next  = bits_reg + {58'd0, nb_sat, 3'b000};
                        state_next = ST_PAD;
                        if (nb_sat == FULL_BYTES)
                        begin
                            // Full last word: marker goes into the next word
                            push_data = s_axis_tdata;
                            pad_next  = PH_MARK;
                        end
                        else
                        begin
                            push_data = (s_axis_tdata & keep_mask) |
                                        (MARKER_WORD >> {nb_sat, 3'b000});
                            pad_next  = PH_ZERO;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                win_ctrl.push = 1'b1;
                case (pad_reg)
                    PH_MARK:
                    begin
                        push_data = MARKER_WORD;
                        pad_next  = PH_ZERO;
                    end
                    PH_ZERO:
                    begin
                        if (slot_reg == LEN_HI_SLOT)
                        begin
                            push_data = bits_reg[63:32];
                            pad_next  = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        push_data = bits_reg[31:0];
                        pad_next  = PH_DONE;
                    end
                    default:
                    begin
                        win_ctrl.push = 1'b0;
                    end
                endcase
            end
            ST_ROUND:
            begin
                // One pass of the shared round unit, advance the window
                win_ctrl.step = 1'b1;
                work_next     = round_out;
                round_next    = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + work_reg.a;
                chain_next[1] = chain_reg[1] + work_reg.b;
                chain_next[2] = chain_reg[2] + work_reg.c;
                chain_next[3] = chain_reg[3] + work_reg.d;
                chain_next[4] = chain_reg[4] + work_reg.e;
                case (pad_reg)
                    PH_IDLE: state_next = ST_IDLE;
                    PH_DONE: state_next = ST_OUT;
                    default: state_next = ST_PAD;
                endcase
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_INDEX)
                    begin
                        // Reinitialise for the next message
                        idx_next   = '0;
                        bits_next  = '0;
                        pad_next   = PH_IDLE;
                        state_next = ST_IDLE;
                        for (int i = 0; i < DIGEST_N; i++)
                        begin
                            chain_next[i] = iv_word(3'(i));
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A push that fills the window starts a compression
        if (win_ctrl.push)
        begin
            slot_next = slot_reg + 4'd1;
            if (slot_reg == LAST_SLOT)
            begin
                state_next = ST_ROUND;
                round_next = '0;
                work_next  = '{a: chain_reg[0], b: chain_reg[1], c: chain_reg[2],
                               d: chain_reg[3], e: chain_reg[4]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pad_reg   <= PH_IDLE;
            slot_reg  <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            bits_reg  <= '0;
            for (int i = 0; i < DIGEST_N; i++)
            begin
                chain_reg[i] <= iv_word(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            pad_reg   <= pad_next;
            slot_reg  <= slot_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            bits_reg  <= bits_next;
            for (int i = 0; i < DIGEST_N; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    // Working variables carry no reset
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

`ifndef SYNTH
    a_idle_round_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (round_reg == '0))
        else $error("round counter not cleared while taking requests");

    a_out_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (slot_reg == '0) && (pad_reg == PH_DONE))
        else $error("digest offered with a partial block or padding pending");

    a_last_round_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && (round_reg == LAST_ROUND) |=> (state_reg == ST_ADD))
        else $error("chaining add did not follow the last round");

    a_digest_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
            s_axis_tready && (bits_reg == '0))
        else $error("engine not reinitialised after the final digest word");
`endif

endmodule

// ===== hw/rtl/sha1_window.sv =====
// SHA-1 sixteen-word schedule window as a shift line with expansion taps.
// Depends on sha1_pkg.
`timescale 1ns / 1ps

module sha1_window
    import sha1_pkg::*;
(
    input  logic        clk,
    input  win_ctrl_t   ctrl,
    input  logic [31:0] push_word,
    output logic [31:0] cur_word
);

    logic [31:0] win_reg [16];
    logic [31:0] expanded;
    logic [31:0] shift_in;

    // Oldest word sits at place 0; W[t+16] from places 13, 8, 2 and 0
    assign expanded = rotl(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0], 1);
    assign shift_in = ctrl.push ? push_word : expanded;
    assign cur_word = win_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctrl.push || ctrl.step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= shift_in;
        end
    end

endmodule

// ===== hw/rtl/sha1_round.sv =====
// SHA-1 round unit: one round of the compression, shared over all 80 rounds.
// Depends on sha1_pkg.
`timescale 1ns / 1ps

module sha1_round
    import sha1_pkg::*;
(
    input  work_t       cur,
    input  logic [31:0] sched_word,
    input  logic [6:0]  round,
    output work_t       nxt
);

    logic [31:0] fv;
    logic [31:0] kv;

    always_comb
    begin
        if (round < 7'd20)
        begin
            fv = (cur.b & cur.c) | (~cur.b & cur.d);
            kv = 32'h5A82_7999;
        end
        else if (round < 7'd40)
        begin
            fv = cur.b ^ cur.c ^ cur.d;
            kv = 32'h6ED9_EBA1;
        end
        else if (round < 7'd60)
        begin
            fv = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            kv = 32'h8F1B_BCDC;
        end
        else
        begin
            fv = cur.b ^ cur.c ^ cur.d;
            kv = 32'hCA62_C1D6;
        end
        nxt.a = rotl(cur.a, 5) + fv + cur.e + sched_word + kv;
        nxt.b = cur.a;
        nxt.c = rotl(cur.b, 30);
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule
